// ===== hdl/glyph_cache_fifo_byte_budget_assert.svh =====
// assertion macros for the glyph cache
`ifndef GLYPH_CACHE_FIFO_BYTE_BUDGET_ASSERT_SVH
`define GLYPH_CACHE_FIFO_BYTE_BUDGET_ASSERT_SVH
`ifndef SYNTH
`define GCFB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define GCFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GCFB_ASSERT(label, cond, msg)
`define GCFB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/gcfb_pkg.sv =====
// package with types, codes and defaults of the glyph cache
`timescale 1ns / 1ps
package gcfb_pkg;
  localparam int SLOTS_DEFAULT = 16;
  localparam logic [23:0] BUDGET_RESET = 24'd65536;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic KIND_NOTICE = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;

  typedef struct packed {
    logic [31:0] owner;
    logic [20:0] codepoint;
    logic [31:0] handle;
    logic [15:0] length;
    logic [31:0] stamp;
  } slot_t;

  typedef struct packed {
    logic key_eq;
    logic stamp_lt;
    logic fits;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_FREE,
    S_OLD_RD,
    S_OLD_CMP,
    S_EV_RD,
    S_EV_DAT,
    S_EV_CHK,
    S_WR,
    S_EMIT
  } state_t;
endpackage

// ===== hdl/gcfb_cmp.sv =====
// shared compare unit: key match, stamp order and budget fit
`timescale 1ns / 1ps
module gcfb_cmp import gcfb_pkg::*; (
  input  logic [31:0] key_owner,
  input  logic [20:0] key_codepoint,
  input  slot_t       entry,
  input  logic [31:0] min_stamp,
  input  logic [23:0] bytes_used,
  input  logic [15:0] req_length,
  input  logic [23:0] budget,
  output cmp_res_t    res
);
  always_comb begin
    res.key_eq = (entry.owner == key_owner) && (entry.codepoint == key_codepoint);
    res.stamp_lt = entry.stamp < min_stamp;
    res.fits = ({1'b0, bytes_used} + {9'd0, req_length}) <= {1'b0, budget};
  end
endmodule

// ===== hdl/gcfb_slot_mem.sv =====
// slot table memory, one write and one registered read port
`timescale 1ns / 1ps
module gcfb_slot_mem import gcfb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  slot_t         wdata,
  input  logic [IW-1:0] raddr,
  output slot_t         rdata
);
  slot_t mem [SLOTS];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/glyph_cache_fifo_byte_budget.sv =====
// top level: glyph cache with insertion order replacement under a byte budget
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  cmd, owner_id, codepoint, bitmap_handle, byte_length
// out      out  out_valid/out_stall kind, status, handle, length, stamp, occupied, last
// cfg      in   cfg_valid/cfg_ready byte_budget (24 bits)
//
// lookup: each slot scanned is read from the slot memory (S_LK_RD), then compared (S_LK_CMP)
// insert: free slot scan, each eviction an oldest stamp scan, a read and a notice, plus the write
// a request takes no new transaction until its final result is in the output register
// output stall only holds the sequencer at each result load
// synchronous active low reset clears valid bits, byte and slot counts, presets stamp and budget; no clearing pass
`timescale 1ns / 1ps
module glyph_cache_fifo_byte_budget import gcfb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_cmd,
  input  logic [31:0]   in_owner_id,
  input  logic [20:0]   in_codepoint,
  input  logic [31:0]   in_bitmap_handle,
  input  logic [15:0]   in_byte_length,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [1:0]    out_status,
  output logic [31:0]   out_handle_out,
  output logic [15:0]   out_length_out,
  output logic [31:0]   out_stamp_out,
  output logic [CW-1:0] out_occupied_out,
  output logic          out_last,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [23:0]   cfg_data
);
`include "glyph_cache_fifo_byte_budget_assert.svh"

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [23:0] budget_r, bytes_r, bytes_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [31:0] next_stamp_r, next_stamp_nxt;
  logic [IW-1:0] idx_r, idx_nxt, old_r, old_nxt;
  logic have_r, have_nxt;
  logic [31:0] min_r, min_nxt;
  logic [31:0] owner_r, owner_nxt, hdl_r, hdl_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic [15:0] len_r, len_nxt;
  logic res_kind_r, res_kind_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic [31:0] res_handle_r, res_handle_nxt, res_stamp_r, res_stamp_nxt;
  logic [15:0] res_length_r, res_length_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_last_r;
  logic [1:0] out_status_r;
  logic [31:0] out_handle_r, out_stamp_r;
  logic [15:0] out_length_r;
  logic [CW-1:0] out_occ_r;
  logic load_out;
  logic in_acc;
  logic mem_we;
  slot_t mem_wdata, mem_rdata;
  cmp_res_t cmp;

  gcfb_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(idx_r), .wdata(mem_wdata),
    .raddr(idx_r), .rdata(mem_rdata)
  );

  gcfb_cmp u_cmp (
    .key_owner(owner_r), .key_codepoint(cp_r), .entry(mem_rdata), .min_stamp(min_r),
    .bytes_used(bytes_r), .req_length(len_r), .budget(budget_r), .res(cmp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_out = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cmd == CMD_INSERT) ? S_FREE : S_LK_RD;
        end
      end
      S_LK_RD: state_nxt = S_LK_CMP;
      S_LK_CMP: begin
        if ((valid_r[idx_r] && cmp.key_eq) || idx_r == LAST_IDX) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_LK_RD;
        end
      end
      S_FREE: begin
        if (!valid_r[idx_r]) begin
          state_nxt = cmp.fits ? S_WR : S_OLD_RD;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_OLD_RD;
        end
      end
      S_OLD_RD: state_nxt = S_OLD_CMP;
      S_OLD_CMP: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = have_nxt ? S_EV_RD : S_EMIT;
        end else begin
          state_nxt = S_OLD_RD;
        end
      end
      S_EV_RD: state_nxt = S_EV_DAT;
      S_EV_DAT: state_nxt = S_EMIT;
      S_EV_CHK: state_nxt = cmp.fits ? S_WR : S_OLD_RD;
      S_WR: state_nxt = S_EMIT;
      S_EMIT: begin
        if (load_out) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt = ret_r;
    valid_nxt = valid_r;
    bytes_nxt = bytes_r;
    occ_nxt = occ_r;
    next_stamp_nxt = next_stamp_r;
    idx_nxt = idx_r;
    old_nxt = old_r;
    have_nxt = have_r;
    min_nxt = min_r;
    owner_nxt = owner_r;
    hdl_nxt = hdl_r;
    cp_nxt = cp_r;
    len_nxt = len_r;
    res_kind_nxt = res_kind_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_length_nxt = res_length_r;
    res_stamp_nxt = res_stamp_r;
    mem_we = 1'b0;
    mem_wdata = '{owner: owner_r, codepoint: cp_r, handle: hdl_r, length: len_r,
                  stamp: next_stamp_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          owner_nxt = in_owner_id;
          cp_nxt = in_codepoint;
          hdl_nxt = in_bitmap_handle;
          len_nxt = in_byte_length;
          idx_nxt = '0;
          have_nxt = 1'b0;
        end
      end
      S_LK_RD: ;
      S_LK_CMP: begin
        ret_nxt = S_IDLE;
        res_kind_nxt = KIND_FINAL;
        if (valid_r[idx_r] && cmp.key_eq) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = mem_rdata.handle;
          res_length_nxt = mem_rdata.length;
          res_stamp_nxt = mem_rdata.stamp;
        end else if (idx_r == LAST_IDX) begin
          res_status_nxt = ST_NOT_FOUND;
          res_handle_nxt = '0;
          res_length_nxt = '0;
          res_stamp_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FREE: begin
        if (!valid_r[idx_r]) begin
          if (!cmp.fits) begin
            idx_nxt = '0;
            have_nxt = 1'b0;
          end
        end else if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
          have_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OLD_RD: ;
      S_OLD_CMP: begin
        if (valid_r[idx_r] && (!have_r || cmp.stamp_lt)) begin
          have_nxt = 1'b1;
          old_nxt = idx_r;
          min_nxt = mem_rdata.stamp;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt = old_nxt;
          ret_nxt = S_IDLE;
          res_kind_nxt = KIND_FINAL;
          res_status_nxt = ST_NO_ROOM;
          res_handle_nxt = '0;
          res_length_nxt = '0;
          res_stamp_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EV_RD: ;
      S_EV_DAT: begin
        valid_nxt[idx_r] = 1'b0;
        bytes_nxt = (bytes_r >= {8'd0, mem_rdata.length}) ?
                    bytes_r - {8'd0, mem_rdata.length} : '0;
        if (occ_r != '0) begin
          occ_nxt = occ_r - 1'b1;
        end
        ret_nxt = S_EV_CHK;
        res_kind_nxt = KIND_NOTICE;
        res_status_nxt = ST_OK;
        res_handle_nxt = mem_rdata.handle;
        res_length_nxt = mem_rdata.length;
        res_stamp_nxt = '0;
      end
      S_EV_CHK: begin
        if (!cmp.fits) begin
          idx_nxt = '0;
          have_nxt = 1'b0;
        end
      end
      S_WR: begin
        mem_we = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        next_stamp_nxt = next_stamp_r + 32'd1;
        bytes_nxt = bytes_r + {8'd0, len_r};
        occ_nxt = occ_r + 1'b1;
        ret_nxt = S_IDLE;
        res_kind_nxt = KIND_FINAL;
        res_status_nxt = ST_OK;
        res_handle_nxt = '0;
        res_length_nxt = '0;
        res_stamp_nxt = '0;
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      valid_r <= '0;
      bytes_r <= '0;
      occ_r <= '0;
      next_stamp_r <= 32'd1;
      budget_r <= BUDGET_RESET;
      have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      valid_r <= valid_nxt;
      bytes_r <= bytes_nxt;
      occ_r <= occ_nxt;
      next_stamp_r <= next_stamp_nxt;
      have_r <= have_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        budget_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    old_r <= old_nxt;
    min_r <= min_nxt;
    owner_r <= owner_nxt;
    hdl_r <= hdl_nxt;
    cp_r <= cp_nxt;
    len_r <= len_nxt;
    res_kind_r <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_length_r <= res_length_nxt;
    res_stamp_r <= res_stamp_nxt;
    if (load_out) begin
      out_kind_r <= res_kind_r;
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_length_r <= res_length_r;
      out_stamp_r <= res_stamp_r;
      out_occ_r <= occ_r;
      out_last_r <= res_kind_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_status = out_status_r;
  assign out_handle_out = out_handle_r;
  assign out_length_out = out_length_r;
  assign out_stamp_out = out_stamp_r;
  assign out_occupied_out = out_occ_r;
  assign out_last = out_last_r;

  `GCFB_ASSERT(a_occ_bound, occ_r <= CW'(SLOTS), "occupied count above slot count")
  `GCFB_ASSERT(a_occ_matches, $countones(valid_r) == occ_r, "occupied count off valid bits")
  `GCFB_ASSERT_NEXT(a_busy_after_accept, in_acc, state_r != S_IDLE, "idle after accept")
  `GCFB_ASSERT(a_final_is_last, !out_valid_r || (out_kind_r == out_last_r),
               "final flag and kind disagree")
endmodule
